[hdl/assert_macros.svh]
// Assertion helpers for the RTL top level, which includes them.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/srrip_pkg.sv]
// Shared types and constants of the signature RRIP replacement engine.
// Depends on nothing.
package srrip_pkg;

  // default configuration
  localparam int SETS_DEF              = 2048;
  localparam int WAYS_DEF              = 16;
  localparam int SIG_BITS_DEF          = 14;
  localparam int DUEL_COUNTER_BITS_DEF = 10;
  localparam int DUEL_PERIOD_DEF       = 64;

  // re-reference levels
  localparam logic [1:0] RR_MAX  = 2'd3;
  localparam logic [1:0] RR_LONG = 2'd2;
  localparam logic [1:0] RR_NEAR = 2'd0;

  // reuse counter limits
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_MIN   = 2'd0;
  localparam logic [1:0] CTR_RESET = 2'd1;

  // random draw that selects near insertion on the bimodal path
  localparam logic [4:0] DRAW_NEAR = 5'd0;

  typedef enum logic {
    ACT_VICTIM = 1'b0,
    ACT_UPDATE = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_TRAIN
  } state_t;

  typedef enum logic [2:0] {
    ROLE_FIRST_DOWN,
    ROLE_FIRST_UP,
    ROLE_SECOND_DOWN,
    ROLE_SECOND_UP,
    ROLE_FOLLOW
  } duel_role_t;

endpackage

[hdl/srrip_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module srrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/signature_rrip_replacement.sv]
// Signature RRIP replacement engine with set dueling: top level.
// Depends on srrip_pkg, srrip_ram and assert_macros.svh.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, in_action .. in_random_draw | input
//  out     | out_valid/out_ready, out_victim_way          | output
//
// A victim request or a hit update passes through ST_ROW; a miss fill also
// passes through ST_TRAIN (ST_ROW reads the evicted line's reuse counter),
// and an update to a way beyond WAYS is dropped in ST_IDLE. This sequence is
// set by the one read port of each memory. After reset a clearing pass over
// max(SETS, 2^SIG_BITS) addresses (16384 by default) initializes both
// memories; in_ready stays low during it. A victim item waits in ST_ROW while
// the previous result is still held in the output register.
// SETS and DUEL_PERIOD must be powers of two.
`include "assert_macros.svh"

module signature_rrip_replacement
  import srrip_pkg::*;
#(
  parameter int SETS              = SETS_DEF,
  parameter int WAYS              = WAYS_DEF,
  parameter int SIG_BITS          = SIG_BITS_DEF,
  parameter int DUEL_COUNTER_BITS = DUEL_COUNTER_BITS_DEF,
  parameter int DUEL_PERIOD       = DUEL_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way_index,
  input  logic        in_was_hit,
  input  logic [15:0] in_program_counter,
  input  logic [4:0]  in_random_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_victim_way
);

  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = $clog2(WAYS);
  localparam int LINE_W     = 4 + SIG_BITS;       // rr[1:0], valid, reused, sig
  localparam int ROW_W      = WAYS * LINE_W;
  localparam int PRED_DEPTH = 1 << SIG_BITS;
  localparam int DUEL_W     = $clog2(DUEL_PERIOD);
  localparam int CLR_N      = (SETS > PRED_DEPTH) ? SETS : PRED_DEPTH;
  localparam int CLR_W      = $clog2(CLR_N);
  localparam logic [DUEL_COUNTER_BITS-1:0] DUEL_MAX   = '1;
  localparam logic [DUEL_COUNTER_BITS-1:0] DUEL_RESET = DUEL_MAX >> 1;
  localparam logic [CLR_W-1:0]             CLR_LAST   = CLR_W'(CLR_N - 1);

  // ---------------------------------------------------------------------
  // Control and item registers
  // ---------------------------------------------------------------------
  state_t                       state_r, state_nxt;
  logic [CLR_W-1:0]             clr_r, clr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [3:0]                   out_way_r, out_way_nxt;
  logic [DUEL_COUNTER_BITS-1:0] duel_first_r, duel_first_nxt;
  logic [DUEL_COUNTER_BITS-1:0] duel_second_r, duel_second_nxt;
  logic [1:0]                   pred_new_r;

  act_t                         action_r;
  logic [SET_W-1:0]             set_r;
  logic [WAY_W-1:0]             way_r;
  logic                         hit_r;
  logic [SIG_BITS-1:0]          sig_r;
  logic [4:0]                   draw_r;

  // ---------------------------------------------------------------------
  // Input decode: wrap set, derive signature, check way range
  // ---------------------------------------------------------------------
  logic                in_accept;
  logic [SET_W+10:0]   set_ext;
  logic [SIG_BITS+13:0] sig_ext;
  logic [WAY_W+3:0]    way_ext;
  logic [SET_W-1:0]    set_in;
  logic [SIG_BITS-1:0] sig_in;
  logic [WAY_W-1:0]    way_in;
  logic                way_ok;
  logic                need_row;

  assign in_accept = in_valid && in_ready;
  assign set_ext   = {{SET_W{1'b0}}, in_set_index};
  assign sig_ext   = {{SIG_BITS{1'b0}}, in_program_counter[15:2]};
  assign way_ext   = {{WAY_W{1'b0}}, in_way_index};
  assign set_in    = set_ext[SET_W-1:0];
  assign sig_in    = sig_ext[SIG_BITS-1:0];
  assign way_in    = way_ext[WAY_W-1:0];
  assign way_ok    = 32'(in_way_index) < 32'(WAYS);
  // drop updates to ways beyond the set
  assign need_row  = (act_t'(in_action) == ACT_VICTIM) || way_ok;

  // ---------------------------------------------------------------------
  // Memories: one row of WAYS lines per set, one reuse counter per signature
  // ---------------------------------------------------------------------
  logic                row_we, row_re;
  logic [SET_W-1:0]    row_waddr;
  logic [ROW_W-1:0]    row_wdata, row_rdata;
  logic                pred_we, pred_re;
  logic [SIG_BITS-1:0] pred_waddr, pred_raddr;
  logic [1:0]          pred_wdata, pred_rdata;

  srrip_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (set_in),
    .rdata (row_rdata)
  );

  srrip_ram #(.WIDTH(2), .DEPTH(PRED_DEPTH)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (pred_waddr),
    .wdata (pred_wdata),
    .re    (pred_re),
    .raddr (pred_raddr),
    .rdata (pred_rdata)
  );

  // ---------------------------------------------------------------------
  // Row unpack; read data holds from the read until the item retires
  // ---------------------------------------------------------------------
  logic [1:0]          rr  [WAYS];
  logic [WAYS-1:0]     vld;
  logic [WAYS-1:0]     reu;
  logic [SIG_BITS-1:0] sg  [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rr[w]  = row_rdata[w*LINE_W +: 2];
      vld[w] = row_rdata[w*LINE_W + 2];
      reu[w] = row_rdata[w*LINE_W + 3];
      sg[w]  = row_rdata[w*LINE_W + 4 +: SIG_BITS];
    end
  end

  // ---------------------------------------------------------------------
  // Victim selection: first invalid way, else age the set and take the
  // first way at the top level (the top is RR_MAX after aging)
  // ---------------------------------------------------------------------
  logic             any_inv, any3, any2, any1;
  logic [1:0]       top, gap;
  logic [WAY_W-1:0] first_inv, first_top, victim;
  logic [WAY_W+3:0] victim_ext;
  logic [ROW_W-1:0] aged_row;

  always_comb begin
    any_inv   = ~&vld;
    any3      = 1'b0;
    any2      = 1'b0;
    any1      = 1'b0;
    first_inv = '0;
    first_top = '0;
    for (int w = 0; w < WAYS; w++) begin
      any3 = any3 | (rr[w] == 2'd3);
      any2 = any2 | (rr[w] == 2'd2);
      any1 = any1 | (rr[w] == 2'd1);
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    gap = RR_MAX - top;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vld[w]) begin
        first_inv = WAY_W'(w);
      end
      if (rr[w] == top) begin
        first_top = WAY_W'(w);
      end
    end
    victim   = any_inv ? first_inv : first_top;
    aged_row = row_rdata;
    for (int w = 0; w < WAYS; w++) begin
      aged_row[w*LINE_W +: 2] = rr[w] + gap;
    end
  end

  assign victim_ext = {4'b0000, victim};

  // ---------------------------------------------------------------------
  // Miss fill: train from the evicted line, pick the insertion level
  // ---------------------------------------------------------------------
  logic                         old_vld, old_reu;
  logic [SIG_BITS-1:0]          old_sig;
  logic [1:0]                   trained, ctr_new, level;
  logic [DUEL_W+SET_W-1:0]      duel_ext;
  logic [DUEL_W-1:0]            duel_pos;
  duel_role_t                   role;
  logic [DUEL_COUNTER_BITS-1:0] first_upd, second_upd;
  logic [1:0]                   bimodal_level;

  assign old_vld  = vld[way_r];
  assign old_reu  = reu[way_r];
  assign old_sig  = sg[way_r];
  assign duel_ext = {{DUEL_W{1'b0}}, set_r};
  assign duel_pos = duel_ext[DUEL_W-1:0];
  assign bimodal_level = (draw_r == DRAW_NEAR) ? RR_NEAR : RR_LONG;

  always_comb begin
    // saturating train of the evicted signature's counter
    if (old_reu) begin
      trained = (pred_rdata == CTR_MAX) ? pred_rdata : pred_rdata + 2'd1;
    end else begin
      trained = (pred_rdata == CTR_MIN) ? pred_rdata : pred_rdata - 2'd1;
    end
    // the new line sees the freshly trained counter when signatures alias
    ctr_new = (old_vld && (old_sig == sig_r)) ? trained : pred_new_r;

    priority if (duel_pos == DUEL_W'(0)) begin
      role = ROLE_FIRST_DOWN;
    end else if (duel_pos == DUEL_W'(1)) begin
      role = ROLE_FIRST_UP;
    end else if (duel_pos == DUEL_W'(2)) begin
      role = ROLE_SECOND_DOWN;
    end else if (duel_pos == DUEL_W'(3)) begin
      role = ROLE_SECOND_UP;
    end else begin
      role = ROLE_FOLLOW;
    end

    first_upd  = duel_first_r;
    second_upd = duel_second_r;
    unique case (role)
      ROLE_FIRST_DOWN: begin
        if (duel_first_r != '0) first_upd = duel_first_r - 1'b1;
      end
      ROLE_FIRST_UP: begin
        if (duel_first_r != DUEL_MAX) first_upd = duel_first_r + 1'b1;
      end
      ROLE_SECOND_DOWN: begin
        if (duel_second_r != '0) second_upd = duel_second_r - 1'b1;
      end
      ROLE_SECOND_UP: begin
        if (duel_second_r != DUEL_MAX) second_upd = duel_second_r + 1'b1;
      end
      default: begin
      end
    endcase

    priority if (ctr_new == CTR_MAX) begin
      level = RR_NEAR;
    end else if (ctr_new == CTR_MAX - 2'd1) begin
      unique case (role)
        ROLE_FIRST_DOWN:  level = RR_NEAR;
        ROLE_FIRST_UP:    level = RR_LONG;
        ROLE_SECOND_DOWN: level = RR_LONG;
        ROLE_SECOND_UP:   level = bimodal_level;
        default: begin
          priority if (first_upd > DUEL_RESET) begin
            level = RR_NEAR;
          end else if (second_upd > DUEL_RESET) begin
            level = RR_LONG;
          end else begin
            level = bimodal_level;
          end
        end
      endcase
    end else begin
      level = RR_MAX;
    end
  end

  // ---------------------------------------------------------------------
  // Row images for write-back
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] clear_row, hit_row, fill_row;

  always_comb begin
    clear_row = '0;
    hit_row   = row_rdata;
    fill_row  = row_rdata;
    for (int w = 0; w < WAYS; w++) begin
      clear_row[w*LINE_W +: 2] = RR_MAX;
      if (WAY_W'(w) == way_r) begin
        hit_row[w*LINE_W +: 2]               = RR_NEAR;
        hit_row[w*LINE_W + 3]                = 1'b1;
        fill_row[w*LINE_W +: 2]              = level;
        fill_row[w*LINE_W + 2]               = 1'b1;
        fill_row[w*LINE_W + 3]               = 1'b0;
        fill_row[w*LINE_W + 4 +: SIG_BITS]   = sig_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept && need_row) state_nxt = ST_ROW;
      end
      ST_ROW: begin
        priority if (action_r == ACT_VICTIM) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (hit_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_TRAIN;
        end
      end
      ST_TRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs of the sequencer: memory ports, result, dueling counters
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready        = 1'b0;
    clr_nxt         = clr_r;
    row_re          = 1'b0;
    row_we          = 1'b0;
    row_waddr       = set_r;
    row_wdata       = fill_row;
    pred_re         = 1'b0;
    pred_raddr      = sig_in;
    pred_we         = 1'b0;
    pred_waddr      = old_sig;
    pred_wdata      = trained;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_way_nxt     = out_way_r;
    duel_first_nxt  = duel_first_r;
    duel_second_nxt = duel_second_r;
    unique case (state_r)
      ST_CLEAR: begin
        // sweep both memories together; the shorter one is rewritten
        clr_nxt    = clr_r + 1'b1;
        row_we     = 1'b1;
        row_waddr  = clr_r[SET_W-1:0];
        row_wdata  = clear_row;
        pred_we    = 1'b1;
        pred_waddr = clr_r[SIG_BITS-1:0];
        pred_wdata = CTR_RESET;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        row_re   = in_accept && need_row;
        pred_re  = in_accept && need_row;
      end
      ST_ROW: begin
        priority if (action_r == ACT_VICTIM) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_way_nxt   = victim_ext[3:0];
            row_we        = !any_inv;
            row_wdata     = aged_row;
          end
        end else if (hit_r) begin
          row_we    = 1'b1;
          row_wdata = hit_row;
        end else begin
          // fetch the evicted line's counter
          pred_re    = 1'b1;
          pred_raddr = old_sig;
        end
      end
      ST_TRAIN: begin
        row_we          = 1'b1;
        pred_we         = old_vld;
        duel_first_nxt  = first_upd;
        duel_second_nxt = second_upd;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      duel_first_r  <= DUEL_RESET;
      duel_second_r <= DUEL_RESET;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      out_valid_r   <= out_valid_nxt;
      duel_first_r  <= duel_first_nxt;
      duel_second_r <= duel_second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_way_r <= out_way_nxt;
    if (in_accept) begin
      action_r <= act_t'(in_action);
      set_r    <= set_in;
      way_r    <= way_in;
      hit_r    <= in_was_hit;
      sig_r    <= sig_in;
      draw_r   <= in_random_draw;
    end
    // capture the new signature's counter before the port is reused
    if (state_r == ST_ROW) begin
      pred_new_r <= pred_rdata;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_IMPL(a_result_from_row, $rose(out_valid_r), $past(state_r) == ST_ROW, "result not from row stage")
  `ASSERT_IMPL(a_train_after_row, state_r == ST_TRAIN, $past(state_r) == ST_ROW, "train stage out of order")
  `ASSERT_IMPL(a_pred_write_stage, pred_we, (state_r == ST_CLEAR) || (state_r == ST_TRAIN), "predictor written outside clear or train")
  `ASSERT_NEXT(a_row_read_then_row, row_re, state_r == ST_ROW, "row read not followed by row stage")

endmodule

[dv/tb_signature_rrip_replacement.sv]
`timescale 1ns / 1ps
// Self-checking testbench for signature_rrip_replacement (victim choice and SHiP-style training).
// Depends on srrip_pkg and the RTL of the block; predicts every victim way with its own model.
module tb_signature_rrip_replacement;
  import srrip_pkg::*;

  localparam int NUM_SETS  = SETS_DEF;
  localparam int NUM_WAYS  = WAYS_DEF;
  localparam int NUM_LINES = NUM_SETS * NUM_WAYS;
  localparam int NUM_SIGS  = 1 << SIG_BITS_DEF;
  localparam int PSEL_TOP  = (1 << DUEL_COUNTER_BITS_DEF) - 1;
  localparam int PSEL_MID  = PSEL_TOP >> 1;

  // one request as it sits on the input channel
  typedef struct {
    act_t        action;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic        was_hit;
    logic [15:0] program_counter;
    logic [4:0]  random_draw;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [10:0] in_set_index = '0;
  logic [3:0]  in_way_index = '0;
  logic        in_was_hit = 1'b0;
  logic [15:0] in_program_counter = '0;
  logic [4:0]  in_random_draw = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_victim_way;

  // own copy of the replacement state
  logic [1:0]                line_level [NUM_LINES];
  logic                      line_live  [NUM_LINES];
  logic [SIG_BITS_DEF-1:0]   line_sig   [NUM_LINES];
  logic                      line_hot   [NUM_LINES];
  logic [1:0]                reuse_ctr  [NUM_SIGS];
  logic [DUEL_COUNTER_BITS_DEF-1:0] psel_near;
  logic [DUEL_COUNTER_BITS_DEF-1:0] psel_long;

  access_t       pending_accesses [$];   // waiting to be driven
  access_t       held_access;            // the item on the input ports
  logic [3:0]    victim_ways_due [$];    // expected victim ways, oldest first
  bit [NUM_WAYS-1:0] planned_valid [NUM_SETS];  // ways that some queued fill makes valid

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  // sets used most: the four dueling roles (130 and 1985 lead too) plus followers 4 and 2047
  logic [10:0] set_pool [8] = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd130, 11'd1985, 11'd2047};
  // a handful of signatures so that reuse counters train both ways
  logic [SIG_BITS_DEF-1:0] sig_pool [6] =
    '{14'h0000, 14'h3FFF, 14'h1555, 14'h2AAA, 14'h0F0F, 14'h30F0};

  int send_pct_by_phase [3] = '{28, 67, 0};
  int recv_pct_by_phase [3] = '{67, 28, 0};

  signature_rrip_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_set_index      (in_set_index),
    .in_way_index      (in_way_index),
    .in_was_hit        (in_was_hit),
    .in_program_counter(in_program_counter),
    .in_random_draw    (in_random_draw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_victim_way    (out_victim_way)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Replacement model
  // ---------------------------------------------------------------------------
  function automatic void clear_model();
    for (int i = 0; i < NUM_LINES; i++) begin
      line_level[i] = RR_MAX;
      line_live[i]  = 1'b0;
      line_sig[i]   = '0;
      line_hot[i]   = 1'b0;
    end
    for (int i = 0; i < NUM_SIGS; i++) reuse_ctr[i] = CTR_RESET;
    psel_near = DUEL_COUNTER_BITS_DEF'(PSEL_MID);
    psel_long = DUEL_COUNTER_BITS_DEF'(PSEL_MID);
  endfunction

  // a zero draw on the bimodal path inserts near, anything else long
  function automatic logic [1:0] bimodal_level(input logic [4:0] draw);
    return (draw == DRAW_NEAR) ? RR_NEAR : RR_LONG;
  endfunction

  // Apply one accepted item to the model; queue the victim way it returns.
  function automatic void apply_access(input access_t a);
    int unsigned base;
    int unsigned idx;
    int unsigned dset;
    logic [1:0]  top;
    logic [1:0]  gap;
    logic [1:0]  ctr;
    logic [1:0]  lvl;
    logic [3:0]  pick;
    bit          found;
    duel_role_t  role;
    logic [SIG_BITS_DEF-1:0] sig;
    logic [SIG_BITS_DEF-1:0] old_sig;

    base = (int'(a.set_index) % NUM_SETS) * NUM_WAYS;

    if (a.action == ACT_VICTIM) begin
      found = 1'b0;
      pick = '0;
      // first invalid way wins outright
      for (int w = 0; w < NUM_WAYS; w++)
        if (!found && !line_live[base + w]) begin
          pick = 4'(w);
          found = 1'b1;
        end
      if (!found) begin
        // age the whole set so that its oldest line reaches the distant level
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
          if (line_level[base + w] > top) top = line_level[base + w];
        gap = RR_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++) line_level[base + w] = line_level[base + w] + gap;
        for (int w = 0; w < NUM_WAYS; w++)
          if (!found && line_level[base + w] == RR_MAX) begin
            pick = 4'(w);
            found = 1'b1;
          end
      end
      victim_ways_due.push_back(pick);
      return;
    end

    // drop updates to a way the cache does not have
    if (int'(a.way_index) >= NUM_WAYS) return;
    idx = base + a.way_index;

    // hit: promote, even when the line is not valid
    if (a.was_hit) begin
      line_level[idx] = RR_NEAR;
      line_hot[idx]   = 1'b1;
      return;
    end

    dset = int'(a.set_index) % DUEL_PERIOD_DEF;
    case (dset)
      0:       role = ROLE_FIRST_DOWN;
      1:       role = ROLE_FIRST_UP;
      2:       role = ROLE_SECOND_DOWN;
      3:       role = ROLE_SECOND_UP;
      default: role = ROLE_FOLLOW;
    endcase

    // move the dueling counters on misses in the leader sets, saturating
    case (role)
      ROLE_FIRST_DOWN:  if (psel_near != 0) psel_near--;
      ROLE_FIRST_UP:    if (psel_near != PSEL_TOP) psel_near++;
      ROLE_SECOND_DOWN: if (psel_long != 0) psel_long--;
      ROLE_SECOND_UP:   if (psel_long != PSEL_TOP) psel_long++;
      default: ;
    endcase

    // train the predictor from the line being evicted
    if (line_live[idx]) begin
      old_sig = line_sig[idx];
      if (line_hot[idx]) begin
        if (reuse_ctr[old_sig] != CTR_MAX) reuse_ctr[old_sig]++;
      end else begin
        if (reuse_ctr[old_sig] != CTR_MIN) reuse_ctr[old_sig]--;
      end
    end

    sig = a.program_counter[SIG_BITS_DEF+1:2];
    line_live[idx] = 1'b1;
    line_sig[idx]  = sig;
    line_hot[idx]  = 1'b0;
    ctr = reuse_ctr[sig];

    // insertion level from the predicted reuse of the new signature
    if (ctr == CTR_MAX) begin
      lvl = RR_NEAR;
    end else if (ctr == CTR_MAX - 2'd1) begin
      case (role)
        ROLE_FIRST_DOWN:                 lvl = RR_NEAR;
        ROLE_FIRST_UP, ROLE_SECOND_DOWN: lvl = RR_LONG;
        ROLE_SECOND_UP:                  lvl = bimodal_level(a.random_draw);
        default: begin
          if (psel_near > PSEL_MID)      lvl = RR_NEAR;
          else if (psel_long > PSEL_MID) lvl = RR_LONG;
          else                           lvl = bimodal_level(a.random_draw);
        end
      endcase
    end else begin
      lvl = RR_MAX;
    end
    line_level[idx] = lvl;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_access(input act_t act, input logic [10:0] s, input logic [3:0] w,
                                      input logic h, input logic [15:0] pc, input logic [4:0] d);
    access_t a;
    a.action          = act;
    a.set_index       = s;
    a.way_index       = w;
    a.was_hit         = h;
    a.program_counter = pc;
    a.random_draw     = d;
    if (act == ACT_UPDATE && !h) planned_valid[int'(s) % NUM_SETS][w] = 1'b1;
    pending_accesses.push_back(a);
  endfunction

  // Mostly well-formed traffic on a small pool of sets: fill the set in way
  // order first so it soon runs full, hit on ways that hold lines, and ask
  // for victims often enough that aging gets exercised.
  function automatic void queue_random_access();
    logic [10:0] set_sel;
    logic [3:0]  way_sel;
    logic [15:0] pc_sel;
    logic [4:0]  draw_sel;
    bit [NUM_WAYS-1:0] filled;
    int pick;

    set_sel  = ($urandom_range(0, 9) == 0) ? 11'($urandom) : set_pool[$urandom_range(0, 7)];
    pc_sel   = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                           : {sig_pool[$urandom_range(0, 5)], 2'($urandom)};
    draw_sel = ($urandom_range(0, 3) == 0) ? DRAW_NEAR : 5'($urandom);
    way_sel  = 4'($urandom);
    filled   = planned_valid[int'(set_sel) % NUM_SETS];
    pick     = $urandom_range(0, 99);

    if (pick < 35) begin
      push_access(ACT_VICTIM, set_sel, way_sel, 1'($urandom), pc_sel, draw_sel);
    end else if (pick < 60) begin
      // walk to a valid way; now and then hit an invalid one on purpose
      if (filled != 0 && $urandom_range(0, 9) != 0)
        repeat (NUM_WAYS) if (!filled[way_sel]) way_sel++;
      push_access(ACT_UPDATE, set_sel, way_sel, 1'b1, pc_sel, draw_sel);
    end else begin
      // fill the first empty way while the set still has one
      if (filled != '1 && $urandom_range(0, 4) != 0) begin
        way_sel = '0;
        while (filled[way_sel]) way_sel++;
      end
      push_access(ACT_UPDATE, set_sel, way_sel, 1'b0, pc_sel, draw_sel);
    end
  endfunction

  // Hold the sender until every queued item is taken and every victim is back.
  task automatic wait_until_drained();
    while (pending_accesses.size() != 0 || in_valid || victim_ways_due.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold valid and payload until accepted, idle at random between items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_access(held_access);
      if (!in_valid || in_ready) begin
        if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held_access = pending_accesses.pop_front();
          in_valid           <= 1'b1;
          in_action          <= held_access.action;
          in_set_index       <= held_access.set_index;
          in_way_index       <= held_access.way_index;
          in_was_hit         <= held_access.was_hit;
          in_program_counter <= held_access.program_counter;
          in_random_draw     <= held_access.random_draw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each victim way with the oldest one due, stall at random
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input logic [3:0] want,
                                        input logic [3:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: victim_way expected %0d, got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (victim_ways_due.size() == 0)
          flag_mismatch("result with nothing due", 4'bx, out_victim_way);
        else if (out_victim_way !== victim_ways_due[0])
          flag_mismatch("wrong victim", victim_ways_due.pop_front(), out_victim_way);
        else
          void'(victim_ways_due.pop_front());
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed cases, three random phases, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    clear_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = send_pct_by_phase[0];
    recv_stall_pct = recv_pct_by_phase[0];

    // empty set: first invalid way
    push_access(ACT_VICTIM, 11'd0, 4'd0, 1'b0, 16'h0000, 5'd0);
    // hit on a line never filled: promoted, stays invalid
    push_access(ACT_UPDATE, 11'd0, 4'd5, 1'b1, 16'h0000, 5'd0);
    push_access(ACT_VICTIM, 11'd0, 4'd15, 1'b1, 16'hFFFF, 5'd31);
    // miss in the set that lowers the first dueling counter
    push_access(ACT_UPDATE, 11'd0, 4'd0, 1'b0, 16'h0000, 5'd0);
    push_access(ACT_VICTIM, 11'd0, 4'd0, 1'b0, 16'h0000, 5'd0);
    // fill, reuse and evict in the last set to push a counter up
    push_access(ACT_UPDATE, 11'd2047, 4'd15, 1'b0, 16'hFFFF, 5'd31);
    push_access(ACT_UPDATE, 11'd2047, 4'd15, 1'b1, 16'hFFFF, 5'd31);
    push_access(ACT_UPDATE, 11'd2047, 4'd15, 1'b0, 16'h1234, 5'd0);
    // the leader sets, with the now moderate signature
    push_access(ACT_UPDATE, 11'd1, 4'd0, 1'b0, 16'hFFFF, 5'd5);
    push_access(ACT_UPDATE, 11'd2, 4'd0, 1'b0, 16'hFFFF, 5'd7);
    push_access(ACT_UPDATE, 11'd3, 4'd0, 1'b0, 16'hFFFF, 5'd0);
    push_access(ACT_UPDATE, 11'd3, 4'd1, 1'b0, 16'hFFFC, 5'd9);
    // follower set: second counter ahead, then the first one too
    push_access(ACT_UPDATE, 11'd1029, 4'd3, 1'b0, 16'hFFFF, 5'd0);
    push_access(ACT_UPDATE, 11'd1, 4'd1, 1'b0, 16'hFFFF, 5'd3);
    push_access(ACT_UPDATE, 11'd1029, 4'd4, 1'b0, 16'hFFFF, 5'd0);
    push_access(ACT_VICTIM, 11'd2047, 4'd7, 1'b0, 16'h5555, 5'd10);
    push_access(ACT_VICTIM, 11'd1029, 4'd8, 1'b1, 16'hAAAA, 5'd21);
    // pause the sender until every victim is back
    wait_until_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = send_pct_by_phase[ph];
      recv_stall_pct = recv_pct_by_phase[ph];
      repeat (200) queue_random_access();
      wait_until_drained();
    end

    // let a trailing miss fill finish
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog: clearing pass plus a worst-case paced run, several times over
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
